// ----- sv/apt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package apt_pkg;

	localparam int TIME_W          = 31;
	localparam int DT_W            = 24;
	localparam int SPD_W           = 16;
	localparam int FC_W            = 16;
	localparam int KIND_W          = 2;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 31;
	localparam int SPEED_FRAC_BITS = 8;
	// product of time and frame count, also the dividend/quotient register
	localparam int ACC_W           = TIME_W + FC_W;
	localparam int CNT_W           = 6;
	localparam int STEP_W          = DT_W + SPD_W + 1 - SPEED_FRAC_BITS;
	localparam int SUM_W           = 34;

	localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_PLAY  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_PAUSE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_CLIP_DURATION = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PLAY_SPEED    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE   = 3'd3;

	localparam logic [SPD_W-1:0] SPEED_RESET = 16'd256;

	// last iteration of each serial pass
	localparam logic [CNT_W-1:0] MUL_LAST  = 6'(SPD_W - 1);
	localparam logic [CNT_W-1:0] WRAP_LAST = 6'(TIME_W);
	localparam logic [CNT_W-1:0] FRM_LAST  = 6'(ACC_W - 1);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_STEP_MUL,
		ST_STEP_ADD,
		ST_WRAP_DIV,
		ST_WRAP_FIX,
		ST_FRM_START,
		ST_FRM_MUL,
		ST_FRM_DIV,
		ST_OUT
	} apt_state_t;

	typedef enum logic [2:0] {
		ARITH_HOLD,
		ARITH_LOAD_MUL,
		ARITH_MUL,
		ARITH_LOAD_DIV,
		ARITH_DIV
	} arith_op_t;

	typedef struct packed {
		arith_op_t         op;
		logic [TIME_W-1:0] mcand;
		logic [SPD_W-1:0]  mplr;
		logic [ACC_W-1:0]  dividend;
	} arith_cmd_t;

endpackage

`default_nettype wire

// ----- sv/apt_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface apt_in_if import apt_pkg::*;;
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [DT_W-1:0]   delta_time;

	modport source (output valid, kind, delta_time, input ready);
	modport sink (input valid, kind, delta_time, output ready);
endinterface

interface apt_out_if import apt_pkg::*;;
	logic              valid;
	logic              ready;
	logic [FC_W-1:0]   frame_index;
	logic [TIME_W-1:0] play_time;
	logic              playing;

	modport source (output valid, frame_index, play_time, playing, input ready);
	modport sink (input valid, frame_index, play_time, playing, output ready);
endinterface

`default_nettype wire

// ----- sv/apt_arith.sv -----
`timescale 1ns / 1ps
`default_nettype none

// bit-serial shift-add multiplier and restoring divider sharing one register
module apt_arith import apt_pkg::*; (
	input  wire logic              clk,
	input  wire arith_cmd_t        cmd,
	input  wire logic [TIME_W-1:0] divisor,
	output logic [ACC_W-1:0]       acc,
	output logic [TIME_W-1:0]      rem
);

	logic [ACC_W-1:0]  acc_q;
	logic [TIME_W-1:0] rem_q;
	logic [TIME_W-1:0] mcand_q;
	logic [SPD_W-1:0]  mplr_q;

	logic [TIME_W:0]   mul_sum;
	logic [TIME_W:0]   div_shift;
	logic [TIME_W+1:0] div_trial;
	logic              div_fits;

	always_comb begin
		mul_sum   = {1'b0, acc_q[ACC_W-1:SPD_W]}
			+ (mplr_q[0] ? {1'b0, mcand_q} : '0);
		div_shift = {rem_q, acc_q[ACC_W-1]};
		div_trial = {1'b0, div_shift} - {2'b00, divisor};
		div_fits  = !div_trial[TIME_W+1];
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			ARITH_LOAD_MUL: begin
				acc_q   <= '0;
				rem_q   <= '0;
				mcand_q <= cmd.mcand;
				mplr_q  <= cmd.mplr;
			end
			ARITH_MUL: begin
				acc_q  <= {mul_sum, acc_q[SPD_W-1:1]};
				mplr_q <= {1'b0, mplr_q[SPD_W-1:1]};
			end
			ARITH_LOAD_DIV: begin
				acc_q <= cmd.dividend;
				rem_q <= '0;
			end
			ARITH_DIV: begin
				acc_q <= {acc_q[ACC_W-2:0], div_fits};
				rem_q <= div_fits ? div_trial[TIME_W-1:0] : div_shift[TIME_W-1:0];
			end
			ARITH_HOLD: begin
			end
			default: begin
			end
		endcase
	end

	assign acc = acc_q;
	assign rem = rem_q;

endmodule

`default_nettype wire

// ----- sv/animation_playhead_timer.sv -----
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  beat fields                          handshake
// in_ch     in   kind, delta_time                     valid/ready
// out_ch    out  frame_index, play_time, playing      valid/ready
// cfg       in   cfg_index, cfg_wdata                 cfg_we, no wait
//
// one item at a time; a tick that advances runs the speed multiply, then a modulo
// divide when it wraps, then the frame multiply and divide; play, pause and idle
// ticks run only the frame multiply and divide, and skip those too when the
// clip duration or frame count is zero. the shared multiplier/divider handles
// one bit per cycle.
// arst_n clears the time, the running flag and the output slot, and sets the config registers to their defaults.
// a new item is taken while the previous result still waits on out_ch.
module animation_playhead_timer import apt_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	apt_in_if.sink                     in_ch,
	apt_out_if.source                  out_ch
);

	apt_state_t state_q, state_d;

	logic [TIME_W-1:0] dur_q;
	logic [SPD_W-1:0]  spd_q;
	logic [FC_W-1:0]   fc_q;
	logic              loop_q;

	logic [TIME_W-1:0] time_q;
	logic              run_q;
	logic              negw_q;
	logic              zfrm_q;
	logic [CNT_W-1:0]  cnt_q;

	logic              out_valid_q;
	logic [FC_W-1:0]   out_frame_q;
	logic [TIME_W-1:0] out_time_q;
	logic              out_play_q;

	arith_cmd_t        cmd;
	logic [ACC_W-1:0]  acc;
	logic [TIME_W-1:0] rem;

	logic              accept;
	logic              advance;
	logic [SPD_W-1:0]  spd_mag;
	logic [DT_W+SPD_W:0] prod_ext;
	logic [DT_W+SPD_W:0] prod_sgn;
	logic [STEP_W-1:0] step;
	logic [SUM_W-1:0]  sum;
	logic              pos_ovf;
	logic              neg_ovf;
	logic [31:0]       t32;
	logic [31:0]       neg_mag;
	logic              t_neg;
	logic              t_ge;
	logic              out_free;
	logic [FC_W-1:0]   frame_val;

	assign accept   = in_ch.valid && (state_q == ST_IDLE);
	assign advance  = (in_ch.kind == KIND_TICK) && run_q && (dur_q != '0);
	assign spd_mag  = spd_q[SPD_W-1] ? (~spd_q + 16'd1) : spd_q;
	assign out_free = !out_valid_q || out_ch.ready;

	// signed step, floor of product over 256
	always_comb begin
		prod_ext = {1'b0, acc[DT_W+SPD_W-1:0]};
		prod_sgn = spd_q[SPD_W-1] ? (~prod_ext + 1'b1) : prod_ext;
		step     = prod_sgn[DT_W+SPD_W:SPEED_FRAC_BITS];
		sum      = {3'b000, time_q} + {step[STEP_W-1], step};
		pos_ovf  = !sum[SUM_W-1] && (sum[SUM_W-2:TIME_W] != 2'b00);
		neg_ovf  = sum[SUM_W-1] && (sum[SUM_W-2:TIME_W] != 2'b11);
		priority if (pos_ovf) begin
			t32 = 32'h7FFF_FFFF;
		end else if (neg_ovf) begin
			t32 = 32'h8000_0000;
		end else begin
			t32 = sum[31:0];
		end
		t_neg   = t32[31];
		t_ge    = !t_neg && (t32[TIME_W-1:0] >= dur_q);
		neg_mag = ~t32 + 32'd1;
	end

	always_comb begin
		if (zfrm_q) begin
			frame_val = '0;
		end else if (acc >= {{(ACC_W-FC_W){1'b0}}, fc_q}) begin
			frame_val = fc_q - 16'd1;
		end else begin
			frame_val = acc[FC_W-1:0];
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd.op       = ARITH_HOLD;
		cmd.mcand    = time_q;
		cmd.mplr     = fc_q;
		cmd.dividend = acc;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (advance) begin
						cmd.op    = ARITH_LOAD_MUL;
						cmd.mcand = {{(TIME_W-DT_W){1'b0}}, in_ch.delta_time};
						cmd.mplr  = spd_mag;
						state_d   = ST_STEP_MUL;
					end else begin
						state_d = ST_FRM_START;
					end
				end
			end
			ST_STEP_MUL: begin
				cmd.op = ARITH_MUL;
				if (cnt_q == MUL_LAST) begin
					state_d = ST_STEP_ADD;
				end
			end
			ST_STEP_ADD: begin
				if (loop_q && t_ge) begin
					cmd.op       = ARITH_LOAD_DIV;
					cmd.dividend = {t32, {(ACC_W-32){1'b0}}};
					state_d      = ST_WRAP_DIV;
				end else if (loop_q && t_neg) begin
					cmd.op       = ARITH_LOAD_DIV;
					cmd.dividend = {neg_mag, {(ACC_W-32){1'b0}}};
					state_d      = ST_WRAP_DIV;
				end else begin
					state_d = ST_FRM_START;
				end
			end
			ST_WRAP_DIV: begin
				cmd.op = ARITH_DIV;
				if (cnt_q == WRAP_LAST) begin
					state_d = ST_WRAP_FIX;
				end
			end
			ST_WRAP_FIX: begin
				state_d = ST_FRM_START;
			end
			ST_FRM_START: begin
				if ((dur_q == '0) || (fc_q == '0)) begin
					state_d = ST_OUT;
				end else begin
					cmd.op  = ARITH_LOAD_MUL;
					state_d = ST_FRM_MUL;
				end
			end
			ST_FRM_MUL: begin
				cmd.op = ARITH_MUL;
				if (cnt_q == MUL_LAST) begin
					state_d = ST_FRM_DIV;
				end
			end
			ST_FRM_DIV: begin
				cmd.op = ARITH_DIV;
				if (cnt_q == FRM_LAST) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// iteration counter restarts on every state change
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (state_d != state_q) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + 6'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dur_q  <= '0;
			spd_q  <= SPEED_RESET;
			fc_q   <= '0;
			loop_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CLIP_DURATION: dur_q  <= cfg_wdata[TIME_W-1:0];
				CFG_PLAY_SPEED:    spd_q  <= cfg_wdata[SPD_W-1:0];
				CFG_FRAME_COUNT:   fc_q   <= cfg_wdata[FC_W-1:0];
				CFG_LOOP_ENABLE:   loop_q <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q <= '0;
			run_q  <= 1'b0;
			negw_q <= 1'b0;
			zfrm_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (in_ch.kind == KIND_PLAY) begin
							run_q <= 1'b1;
						end else if (in_ch.kind == KIND_PAUSE) begin
							run_q <= 1'b0;
						end
					end
				end
				ST_STEP_ADD: begin
					negw_q <= t_neg;
					if (t_ge) begin
						if (!loop_q) begin
							time_q <= dur_q;
							run_q  <= 1'b0;
						end
					end else if (t_neg) begin
						if (!loop_q) begin
							time_q <= '0;
							run_q  <= 1'b0;
						end
					end else begin
						time_q <= t32[TIME_W-1:0];
					end
				end
				ST_WRAP_FIX: begin
					// reverse wrap: exact multiple lands on the duration
					time_q <= negw_q ? (dur_q - rem) : rem;
				end
				ST_FRM_START: begin
					zfrm_q <= (dur_q == '0) || (fc_q == '0);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			out_frame_q <= frame_val;
			out_time_q  <= time_q;
			out_play_q  <= run_q;
		end
	end

	apt_arith u_arith (
		.clk     (clk),
		.cmd     (cmd),
		.divisor (dur_q),
		.acc     (acc),
		.rem     (rem)
	);

	assign in_ch.ready        = (state_q == ST_IDLE);
	assign out_ch.valid       = out_valid_q;
	assign out_ch.frame_index = out_frame_q;
	assign out_ch.play_time   = out_time_q;
	assign out_ch.playing     = out_play_q;

endmodule

`default_nettype wire

// ----- sv/apt_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module apt_checker import apt_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_ready,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire logic [FC_W-1:0]   frame_index,
	input wire logic [TIME_W-1:0] play_time,
	input wire logic              playing
);

	// a held result beat keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(frame_index)
			&& $stable(play_time) && $stable(playing))
		else $error("result beat changed while stalled");

	// one item at a time: input closes right after a beat is taken
	a_in_close: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input stayed open after a beat");

	// a fresh result only appears at the end of work, never from idle
	a_out_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without an item in flight");

	// input reopens together with the slot filling
	a_reopen: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_ready) |-> out_valid)
		else $error("input reopened without a result");

endmodule

bind animation_playhead_timer apt_checker u_apt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_ch.valid),
	.in_ready    (in_ch.ready),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.frame_index (out_ch.frame_index),
	.play_time   (out_ch.play_time),
	.playing     (out_ch.playing)
);

`default_nettype wire
